### rtl/core/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg - shared definitions for the SPIR-V entry point finder
// Stream constants, scan phase encoding and the result record.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int MAX_WORDS    = 65536;
	localparam int POS_W        = $clog2(MAX_WORDS + 2);
	localparam int WORD_W       = 32;
	localparam int HALF_W       = 16;
	localparam int OFF_W        = 18;
	localparam int HEADER_WORDS = 5;

	localparam logic [WORD_W-1:0] SPV_MAGIC = 32'h0723_0203;
	localparam logic [HALF_W-1:0] OPC_ENTRY = 16'd15;
	localparam logic [HALF_W-1:0] EP_MIN_LEN = 16'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_OPHEAD,
		PH_BODY,
		PH_EP_MODEL,
		PH_EP_ID,
		PH_EP_NAME,
		PH_FOUND,
		PH_FAIL
	} phase_t;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] name_offset;
	} result_t;

endpackage

### rtl/core/spirv_entry_point_finder.sv
// ----------------------------------------------------------------------------
// spirv_entry_point_finder - locate the first OpEntryPoint name in a module
// Scans a SPIR-V word stream and reports where the entry point name starts.
// ----------------------------------------------------------------------------
// Feed the module one 32-bit little-endian word per transfer, with last set on
// the final word. The block takes one word every cycle unless word_stall is
// raised: each word is latched, and as it advances the walker in spf_scan
// updates its state in a single step (compares, a counter decrement, a
// four-byte zero detect). Exactly one result comes out per stream:
// result_valid rises once the word with last has passed the input register
// and been loaded into the result register. found is set only when word 0
// is the magic number, the walk reaches an OpEntryPoint whose name holds a
// zero byte before the instruction ends, the instruction fits in the stream,
// and the stream is at most MAX_WORDS words long; name_offset is then the byte
// offset of the name from the module start, else 0. Words after the decision
// are consumed silently until last. A result waiting under result_stall stalls
// the word side only when the next latched word is itself a last word.
// ----------------------------------------------------------------------------
module spirv_entry_point_finder import spf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              word_valid,
	output logic              word_stall,
	input  logic [WORD_W-1:0] word,
	input  logic              last,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              found,
	output logic [OFF_W-1:0]  name_offset
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;
	logic              out_free;
	logic              advance;
	result_t           scan_result;
	result_t           result_q;

	// A latched word moves on unless it closes a stream while the result
	// register is still occupied.
	assign advance    = valid_s1 && (!last_s1 || out_free);
	assign word_stall = valid_s1 && !advance;

	// input register: refill whenever the held word advances or is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!word_stall && word_valid) begin
			word_s1 <= word;
			last_s1 <= last;
		end
	end

	spf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.last   (last_s1),
		.result (scan_result)
	);

	// load the result register only on the word that ends the stream
	spf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.result_d (scan_result),
		.stall    (result_stall),
		.free     (out_free),
		.valid    (result_valid),
		.result_q (result_q)
	);

	assign found       = result_q.found;
	assign name_offset = result_q.name_offset;

endmodule

### rtl/core/spf_scan.sv
// ----------------------------------------------------------------------------
// spf_scan - instruction walker
// Holds the per-stream scan state and advances it by one word per step.
// ----------------------------------------------------------------------------
module spf_scan import spf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [WORD_W-1:0] word,
	input  logic              last,
	output result_t           result
);

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d, pos_inc;
	logic [HALF_W-1:0] left_q, left_d, left_dec;
	logic              term_q, term_d, term_new;
	logic [OFF_W-1:0]  held_q, held_d, held_new;
	phase_t            phase_new;
	logic [HALF_W-1:0] len, opc;
	logic [OFF_W-1:0]  off_base;
	logic              zero_byte;

	assign len       = word[WORD_W-1:HALF_W];
	assign opc       = word[HALF_W-1:0];
	assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;
	assign zero_byte = (word[7:0] == 8'h00) || (word[15:8] == 8'h00) ||
	                   (word[23:16] == 8'h00) || (word[31:24] == 8'h00);
	assign off_base  = OFF_W'(pos_q) + OFF_W'(3);
	assign pos_inc   = (pos_q <= POS_W'(MAX_WORDS)) ? pos_q + 1'b1 : pos_q;

	// next state
	always_comb begin
		phase_new = phase_q;
		left_d    = left_q;
		term_new  = term_q;
		held_new  = held_q;
		case (phase_q)
			PH_HEADER: begin
				if (pos_q == '0 && word != SPV_MAGIC) begin
					phase_new = PH_FAIL;
				end else if (pos_q >= POS_W'(HEADER_WORDS - 1)) begin
					phase_new = PH_OPHEAD;
				end
			end
			PH_OPHEAD: begin
				if (len == '0) begin
					phase_new = PH_FAIL;
				end else if (opc == OPC_ENTRY && len >= EP_MIN_LEN) begin
					left_d    = len - 1'b1;
					held_new  = {off_base[OFF_W-3:0], 2'b00};
					term_new  = 1'b0;
					phase_new = PH_EP_MODEL;
				end else if (len > 16'd1) begin
					left_d    = len - 1'b1;
					phase_new = PH_BODY;
				end
			end
			PH_BODY: begin
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_new = PH_OPHEAD;
				end
			end
			PH_EP_MODEL: begin
				left_d    = left_dec;
				phase_new = PH_EP_ID;
			end
			PH_EP_ID: begin
				left_d    = left_dec;
				phase_new = PH_EP_NAME;
			end
			PH_EP_NAME: begin
				term_new = term_q | zero_byte;
				left_d   = left_dec;
				if (left_dec == '0) begin
					phase_new = (term_q | zero_byte) ? PH_FOUND : PH_FAIL;
				end
			end
			default: begin
			end
		endcase

		// drop back to the start of a new module after the last word
		if (last) begin
			phase_d = PH_HEADER;
			pos_d   = '0;
			left_d  = '0;
			term_d  = 1'b0;
			held_d  = '0;
		end else begin
			phase_d = phase_new;
			pos_d   = pos_inc;
			term_d  = term_new;
			held_d  = held_new;
		end
	end

	// outputs
	always_comb begin
		result.found       = (phase_new == PH_FOUND) && (pos_inc <= POS_W'(MAX_WORDS));
		result.name_offset = result.found ? held_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			left_q  <= '0;
			term_q  <= 1'b0;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			left_q  <= left_d;
			term_q  <= term_d;
			held_q  <= held_d;
		end
	end

endmodule

### rtl/core/spf_out.sv
// ----------------------------------------------------------------------------
// spf_out - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module spf_out import spf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_d,
	input  logic    stall,
	output logic    free,
	output logic    valid,
	output result_t result_q
);

	logic valid_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

endmodule
